FILE: hw/rtl/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

	// Storage geometry
	localparam int DEPTH = 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int WW    = 64;

	// Request commands
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_SWAP   = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	// Loop index operations
	localparam logic [2:0] IDX_HOLD  = 3'd0;
	localparam logic [2:0] IDX_COUNT = 3'd1;
	localparam logic [2:0] IDX_POS   = 3'd2;
	localparam logic [2:0] IDX_ZERO  = 3'd3;
	localparam logic [2:0] IDX_INC   = 3'd4;
	localparam logic [2:0] IDX_DEC   = 3'd5;

	// Read address select
	localparam logic [2:0] RA_IDX      = 3'd0;
	localparam logic [2:0] RA_IDX_M1   = 3'd1;
	localparam logic [2:0] RA_IDX_P1   = 3'd2;
	localparam logic [2:0] RA_IDX_HALF = 3'd3;
	localparam logic [2:0] RA_POS      = 3'd4;

	// Write address select
	localparam logic [1:0] WA_IDX      = 2'd0;
	localparam logic [1:0] WA_POS      = 2'd1;
	localparam logic [1:0] WA_IDX_HALF = 2'd2;

	// Write data select
	localparam logic [1:0] WD_WORD  = 2'd0;
	localparam logic [1:0] WD_RDATA = 2'd1;
	localparam logic [1:0] WD_TMP   = 2'd2;

	// Entry count operations
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic [2:0] idx_op;
		logic [2:0] ra_sel;
		logic       we;
		logic [1:0] wa_sel;
		logic [1:0] wd_sel;
		logic       tmp_load;
		logic       half_load;
		logic [1:0] cnt_op;
		logic       st_set;
		logic [1:0] st_val;
		logic       rd_cap;
		logic       out_load;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       pos_gt_count;
		logic       pos_ge_count;
		logic       idx_gt_pos;
		logic       idx_p1_lt_count;
		logic       idx_lt_runs;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_datapath import iss_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      cmd,
	input  wire logic [AW-1:0]   position,
	input  wire logic [WW-1:0]   word_in,
	input  wire ctrl_cmd_t       ctl,
	output dp_stat_t             stat,
	output logic [1:0]           status,
	output logic [WW-1:0]        word_out,
	output logic [CW-1:0]        count_out
);

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rdata_q;

	logic [1:0]    cmd_q;
	logic [AW-1:0] pos_q;
	logic [WW-1:0] word_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] half_q;
	logic [WW-1:0] tmp_q;
	logic [1:0]    st_q;
	logic [WW-1:0] rd_q;

	logic [AW-1:0] idx_m1;
	logic [AW-1:0] idx_p1;
	logic [AW-1:0] idx_half;
	logic [CW-1:0] runs;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [WW-1:0] wdata;

	// Address arithmetic; all live addresses stay at or below the entry count
	assign idx_m1   = idx_q[AW-1:0] - AW'(1);
	assign idx_p1   = idx_q[AW-1:0] + AW'(1);
	assign idx_half = idx_q[AW-1:0] + half_q;
	assign runs     = {1'b0, half_q} + {{AW{1'b0}}, count_q[0]};

	// Status back to controller
	always_comb begin
		stat.cmd             = cmd_q;
		stat.full            = (count_q == CW'(DEPTH));
		stat.pos_gt_count    = ({1'b0, pos_q} > count_q);
		stat.pos_ge_count    = ({1'b0, pos_q} >= count_q);
		stat.idx_gt_pos      = (idx_q > {1'b0, pos_q});
		stat.idx_p1_lt_count = (({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, count_q});
		stat.idx_lt_runs     = (idx_q < runs);
	end

	// Read address mux
	always_comb begin
		unique case (ctl.ra_sel)
			RA_IDX:      raddr = idx_q[AW-1:0];
			RA_IDX_M1:   raddr = idx_m1;
			RA_IDX_P1:   raddr = idx_p1;
			RA_IDX_HALF: raddr = idx_half;
			RA_POS:      raddr = pos_q;
			default:     raddr = pos_q;
		endcase
	end

	// Write address and data mux
	always_comb begin
		unique case (ctl.wa_sel)
			WA_IDX:      waddr = idx_q[AW-1:0];
			WA_POS:      waddr = pos_q;
			WA_IDX_HALF: waddr = idx_half;
			default:     waddr = pos_q;
		endcase
		unique case (ctl.wd_sel)
			WD_WORD:  wdata = word_q;
			WD_RDATA: wdata = rdata_q;
			WD_TMP:   wdata = tmp_q;
			default:  wdata = word_q;
		endcase
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.cnt_op)
				CNT_INC:  count_q <= count_q + CW'(1);
				CNT_DEC:  count_q <= count_q - CW'(1);
				default:  count_q <= count_q;
			endcase
		end
	end

	// Request, loop and result payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			pos_q  <= position;
			word_q <= word_in;
			st_q   <= ST_DONE;
			rd_q   <= '0;
		end
		unique case (ctl.idx_op)
			IDX_COUNT: idx_q <= count_q;
			IDX_POS:   idx_q <= {1'b0, pos_q};
			IDX_ZERO:  idx_q <= '0;
			IDX_INC:   idx_q <= idx_q + CW'(1);
			IDX_DEC:   idx_q <= idx_q - CW'(1);
			default:   idx_q <= idx_q;
		endcase
		if (ctl.half_load) begin
			half_q <= count_q[CW-1:1];
		end
		if (ctl.tmp_load) begin
			tmp_q <= rdata_q;
		end
		if (ctl.st_set) begin
			st_q <= ctl.st_val;
		end
		if (ctl.rd_cap) begin
			rd_q <= rdata_q;
		end
		if (ctl.out_load) begin
			status    <= st_q;
			word_out  <= rd_q;
			count_out <= count_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/iss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_ctrl import iss_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      ctl
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_INS_CHK = 4'd2;
	localparam logic [3:0] S_INS_WR  = 4'd3;
	localparam logic [3:0] S_REM_CHK = 4'd4;
	localparam logic [3:0] S_REM_WR  = 4'd5;
	localparam logic [3:0] S_SW_RDA  = 4'd6;
	localparam logic [3:0] S_SW_RDB  = 4'd7;
	localparam logic [3:0] S_SW_WRA  = 4'd8;
	localparam logic [3:0] S_SW_WRB  = 4'd9;
	localparam logic [3:0] S_RD_CAP  = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_FULL;
							state_d    = S_DONE;
						end else if (stat.pos_gt_count) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_BAD;
							state_d    = S_DONE;
						end else begin
							ctl.idx_op = IDX_COUNT;
							state_d    = S_INS_CHK;
						end
					end
					CMD_REMOVE: begin
						if (stat.pos_ge_count) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_BAD;
							state_d    = S_DONE;
						end else begin
							ctl.idx_op = IDX_POS;
							state_d    = S_REM_CHK;
						end
					end
					CMD_SWAP: begin
						ctl.idx_op    = IDX_ZERO;
						ctl.half_load = 1'b1;
						state_d       = S_SW_RDA;
					end
					CMD_READ: begin
						if (stat.pos_ge_count) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_BAD;
							state_d    = S_DONE;
						end else begin
							ctl.ra_sel = RA_POS;
							state_d    = S_RD_CAP;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			// Insert: move entries up from the top, then drop the word in
			S_INS_CHK: begin
				if (stat.idx_gt_pos) begin
					ctl.ra_sel = RA_IDX_M1;
					state_d    = S_INS_WR;
				end else begin
					ctl.we     = 1'b1;
					ctl.wa_sel = WA_POS;
					ctl.wd_sel = WD_WORD;
					ctl.cnt_op = CNT_INC;
					state_d    = S_DONE;
				end
			end
			S_INS_WR: begin
				ctl.we     = 1'b1;
				ctl.wa_sel = WA_IDX;
				ctl.wd_sel = WD_RDATA;
				ctl.idx_op = IDX_DEC;
				state_d    = S_INS_CHK;
			end
			// Remove: move entries down from the position
			S_REM_CHK: begin
				if (stat.idx_p1_lt_count) begin
					ctl.ra_sel = RA_IDX_P1;
					state_d    = S_REM_WR;
				end else begin
					ctl.cnt_op = CNT_DEC;
					state_d    = S_DONE;
				end
			end
			S_REM_WR: begin
				ctl.we     = 1'b1;
				ctl.wa_sel = WA_IDX;
				ctl.wd_sel = WD_RDATA;
				ctl.idx_op = IDX_INC;
				state_d    = S_REM_CHK;
			end
			// Swap halves: read both, write both, in order
			S_SW_RDA: begin
				if (stat.idx_lt_runs) begin
					ctl.ra_sel = RA_IDX;
					state_d    = S_SW_RDB;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SW_RDB: begin
				ctl.ra_sel   = RA_IDX_HALF;
				ctl.tmp_load = 1'b1;
				state_d      = S_SW_WRA;
			end
			S_SW_WRA: begin
				ctl.we     = 1'b1;
				ctl.wa_sel = WA_IDX;
				ctl.wd_sel = WD_RDATA;
				state_d    = S_SW_WRB;
			end
			S_SW_WRB: begin
				ctl.we     = 1'b1;
				ctl.wa_sel = WA_IDX_HALF;
				ctl.wd_sel = WD_TMP;
				ctl.idx_op = IDX_INC;
				state_d    = S_SW_RDA;
			end
			S_RD_CAP: begin
				ctl.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			// Hand result to the output register once it is free
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_sequence_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered store of up to 256 64-bit words with insert, remove, swap-halves and
// read by position; each request returns one transaction with status, read word
// and the entry count after the request. The entries live in a single memory
// with one write port and one registered read port, and each request walks
// the affected entries through it: insert moves the entries from the top down
// to the position, remove moves those above the position down, and swap-halves
// exchanges the entries pair by pair. One request is processed at a time; a new
// request is taken while the previous result still sits in the output register.

module indexed_sequence_store import iss_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    cmd,
	input  wire logic [7:0]    position,
	input  wire logic [63:0]   word_in,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [1:0]         status,
	output logic [63:0]        word_out,
	output logic [8:0]         count_out
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// Sequencer
	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Memory, counters and result registers
	iss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.position  (position),
		.word_in   (word_in),
		.ctl       (ctl),
		.stat      (stat),
		.status    (status),
		.word_out  (word_out),
		.count_out (count_out)
	);

endmodule

`default_nettype wire
